@@ rtl/source_text_tokenizer_assert.svh @@
// assertion macros for the source text tokenizer
// expects clk and rst_n in the scope that uses them
`ifndef SOURCE_TEXT_TOKENIZER_ASSERT_SVH
`define SOURCE_TEXT_TOKENIZER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define STT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tokenizer assertion failed");

// next-cycle implication, checked out of reset
`define STT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tokenizer assertion failed");

`endif

@@ rtl/stt_pkg.sv @@
// shared types, constants and helpers of the source text tokenizer
// used by stt_lexer, stt_token_fifo and source_text_tokenizer
package stt_pkg;

  localparam int LINE_BITS   = 16;
  localparam int LENGTH_BITS = 8;
  localparam int FIFO_DEPTH  = 8;
  localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
  localparam int PUSH_MAX    = 3;

  localparam logic [LINE_BITS-1:0]   POS_MAX = '1;
  localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;
  localparam logic [5:0]             FRAC_MAX = 6'd63;
  localparam logic [63:0]            VAL_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

  localparam logic [4:0] K_END     = 5'd0;
  localparam logic [4:0] K_NEWLINE = 5'd1;
  localparam logic [4:0] K_SEMI    = 5'd2;
  localparam logic [4:0] K_LPAREN  = 5'd3;
  localparam logic [4:0] K_RPAREN  = 5'd4;
  localparam logic [4:0] K_ASSIGN  = 5'd5;
  localparam logic [4:0] K_COLON   = 5'd6;
  localparam logic [4:0] K_PLUS    = 5'd7;
  localparam logic [4:0] K_MINUS   = 5'd8;
  localparam logic [4:0] K_STAR    = 5'd9;
  localparam logic [4:0] K_SLASH   = 5'd10;
  localparam logic [4:0] K_IDENT   = 5'd11;
  localparam logic [4:0] K_INT     = 5'd12;
  localparam logic [4:0] K_DEC     = 5'd13;
  localparam logic [4:0] K_CHAR    = 5'd14;
  localparam logic [4:0] K_STRING  = 5'd15;
  localparam logic [4:0] K_ERROR   = 5'd16;

  localparam logic [1:0] E_NONE     = 2'd0;
  localparam logic [1:0] E_BAD_CHAR = 2'd1;
  localparam logic [1:0] E_NO_CLOSE = 2'd2;
  localparam logic [1:0] E_UNKNOWN  = 2'd3;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_QUOTE  = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_STAR   = 8'h2A;

  typedef enum logic [11:0] {
    M_IDLE    = 12'b0000_0000_0001,
    M_IDENT   = 12'b0000_0000_0010,
    M_INT     = 12'b0000_0000_0100,
    M_INT_DOT = 12'b0000_0000_1000,
    M_FRAC    = 12'b0000_0001_0000,
    M_DOT     = 12'b0000_0010_0000,
    M_UNDER   = 12'b0000_0100_0000,
    M_SLASH   = 12'b0000_1000_0000,
    M_COMMENT = 12'b0001_0000_0000,
    M_CHAR1   = 12'b0010_0000_0000,
    M_CHAR2   = 12'b0100_0000_0000,
    M_STRING  = 12'b1000_0000_0000
  } lex_mode_t;

  typedef struct packed {
    logic [4:0]             kind;
    logic [1:0]             code;
    logic [63:0]            value;
    logic [5:0]             frac;
    logic [LENGTH_BITS-1:0] len;
    logic [LINE_BITS-1:0]   ln;
    logic [LINE_BITS-1:0]   col;
    logic                   last;
  } tok_t;

  typedef struct packed {
    logic [1:0]           cnt;
    tok_t [PUSH_MAX-1:0]  tok;
  } push_t;

  function automatic logic is_digit(logic [7:0] b);
    return (b >= 8'h30) && (b <= 8'h39);
  endfunction

  function automatic logic is_alpha(logic [7:0] b);
    return ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A));
  endfunction

  function automatic logic is_ident(logic [7:0] b);
    return (b == CH_UNDER) || is_digit(b) || is_alpha(b);
  endfunction

  function automatic logic is_blank(logic [7:0] b);
    return (b == 8'h20) || (b == 8'h09) || (b == 8'h0B) || (b == 8'h0C) || (b == 8'h0D);
  endfunction

  function automatic logic char_ok(logic [7:0] b);
    return ((b >= 8'h20) && (b <= 8'h7E)) || ((b >= 8'h09) && (b <= 8'h0D));
  endfunction

  // v*10 + digit, saturating at the largest signed value
  function automatic logic [63:0] acc_digit(logic [63:0] v, logic [7:0] b);
    logic [67:0] t;
    t = {1'b0, v, 3'b000} + {3'b000, v, 1'b0} + {64'd0, b[3:0]};
    return (t > {4'd0, VAL_MAX}) ? VAL_MAX : t[63:0];
  endfunction

  function automatic tok_t make_tok(logic [4:0] kind, logic [1:0] code, logic [63:0] value,
                                    logic [5:0] frac, logic [LENGTH_BITS-1:0] len,
                                    logic [LINE_BITS-1:0] ln, logic [LINE_BITS-1:0] col);
    tok_t t;
    t.kind  = kind;
    t.code  = code;
    t.value = value;
    t.frac  = frac;
    t.len   = len;
    t.ln    = ln;
    t.col   = col;
    t.last  = 1'b0;
    return t;
  endfunction

endpackage

@@ rtl/stt_lexer.sv @@
// lexer state and per-byte token generation, up to three tokens a beat
// depends on stt_pkg
module stt_lexer
  import stt_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic [7:0] text_byte,
  output push_t      push
);

  lex_mode_t              mode_r, mode_nxt;
  logic [63:0]            acc_r, acc_nxt;
  logic [5:0]             frac_r, frac_nxt;
  logic [LENGTH_BITS-1:0] len_r, len_nxt;
  logic [LINE_BITS-1:0]   line_r, line_nxt, col_r, col_nxt;
  logic [LINE_BITS-1:0]   tline_r, tline_nxt, tcol_r, tcol_nxt;
  logic [LINE_BITS-1:0]   dline_r, dline_nxt, dcol_r, dcol_nxt;
  logic                   lwn_r, lwn_nxt;

  logic                   emit_a, emit_b, do_start;
  tok_t                   tok_a, tok_b;
  logic                   lwn_eff;
  logic                   st_emit;
  tok_t                   st_tok;
  lex_mode_t              st_mode;
  logic [63:0]            st_acc;
  logic [LENGTH_BITS-1:0] st_len;
  logic [63:0]            accd;
  logic [63:0]            byte_val;
  logic [1:0]             n;

  assign accd     = acc_digit(acc_r, text_byte);
  assign byte_val = {56'd0, text_byte};
  assign lwn_eff  = emit_a ? 1'b0 : lwn_r;

  // token start for the current byte
  always_comb begin
    st_emit = 1'b0;
    st_tok  = make_tok(K_END, E_NONE, '0, '0, '0, line_r, col_r);
    st_mode = M_IDLE;
    st_acc  = '0;
    st_len  = '0;
    if (text_byte == CH_NUL) begin
      st_emit = 1'b1;
    end else if (text_byte == CH_NL) begin
      st_emit     = !lwn_eff;
      st_tok.kind = K_NEWLINE;
    end else if (is_blank(text_byte)) begin
      st_mode = M_IDLE;
    end else if (text_byte == CH_QUOTE) begin
      st_mode = M_CHAR1;
    end else if (text_byte == CH_DQUOTE) begin
      st_mode = M_STRING;
    end else if (is_digit(text_byte)) begin
      st_acc  = {60'd0, text_byte[3:0]};
      st_mode = M_INT;
    end else if (text_byte == CH_DOT) begin
      st_mode = M_DOT;
    end else if (is_alpha(text_byte)) begin
      st_len  = LENGTH_BITS'(1);
      st_mode = M_IDENT;
    end else if (text_byte == CH_UNDER) begin
      st_mode = M_UNDER;
    end else if (text_byte == CH_SLASH) begin
      st_mode = M_SLASH;
    end else begin
      st_emit = 1'b1;
      unique case (text_byte)
        CH_SEMI:   st_tok.kind = K_SEMI;
        CH_LPAREN: st_tok.kind = K_LPAREN;
        CH_RPAREN: st_tok.kind = K_RPAREN;
        CH_EQ:     st_tok.kind = K_ASSIGN;
        CH_COLON:  st_tok.kind = K_COLON;
        CH_PLUS:   st_tok.kind = K_PLUS;
        CH_MINUS:  st_tok.kind = K_MINUS;
        CH_STAR:   st_tok.kind = K_STAR;
        default: begin
          st_tok.kind  = K_ERROR;
          st_tok.code  = E_UNKNOWN;
          st_tok.value = byte_val;
        end
      endcase
    end
  end

  // mode transitions and pending-token emission
  always_comb begin
    mode_nxt  = mode_r;
    acc_nxt   = acc_r;
    frac_nxt  = frac_r;
    len_nxt   = len_r;
    tline_nxt = tline_r;
    tcol_nxt  = tcol_r;
    dline_nxt = dline_r;
    dcol_nxt  = dcol_r;
    emit_a    = 1'b0;
    emit_b    = 1'b0;
    do_start  = 1'b0;
    tok_a     = make_tok(K_ERROR, E_UNKNOWN, {56'd0, CH_DOT}, '0, '0, tline_r, tcol_r);
    tok_b     = make_tok(K_ERROR, E_UNKNOWN, {56'd0, CH_DOT}, '0, '0, dline_r, dcol_r);
    unique case (mode_r)
      M_IDLE: begin
        do_start = 1'b1;
      end
      M_IDENT: begin
        if (is_ident(text_byte)) begin
          if (len_r != LEN_MAX) len_nxt = len_r + LENGTH_BITS'(1);
        end else begin
          emit_a   = 1'b1;
          tok_a    = make_tok(K_IDENT, E_NONE, '0, '0, len_r, tline_r, tcol_r);
          do_start = 1'b1;
        end
      end
      M_INT: begin
        if (is_digit(text_byte)) begin
          acc_nxt = accd;
        end else if (text_byte == CH_DOT) begin
          dline_nxt = line_r;
          dcol_nxt  = col_r;
          mode_nxt  = M_INT_DOT;
        end else begin
          emit_a   = 1'b1;
          tok_a    = make_tok(K_INT, E_NONE, acc_r, '0, '0, tline_r, tcol_r);
          do_start = 1'b1;
        end
      end
      M_INT_DOT: begin
        if (is_digit(text_byte)) begin
          acc_nxt  = accd;
          frac_nxt = 6'd1;
          mode_nxt = M_FRAC;
        end else begin
          emit_a   = 1'b1;
          tok_a    = make_tok(K_INT, E_NONE, acc_r, '0, '0, tline_r, tcol_r);
          emit_b   = 1'b1;
          do_start = 1'b1;
        end
      end
      M_DOT: begin
        if (is_digit(text_byte)) begin
          acc_nxt  = accd;
          frac_nxt = 6'd1;
          mode_nxt = M_FRAC;
        end else begin
          emit_a   = 1'b1;
          do_start = 1'b1;
        end
      end
      M_FRAC: begin
        if (is_digit(text_byte)) begin
          acc_nxt = accd;
          if (frac_r != FRAC_MAX) frac_nxt = frac_r + 6'd1;
        end else begin
          emit_a   = 1'b1;
          tok_a    = make_tok(K_DEC, E_NONE, acc_r, frac_r, '0, tline_r, tcol_r);
          do_start = 1'b1;
        end
      end
      M_UNDER: begin
        if (is_ident(text_byte)) begin
          len_nxt  = LENGTH_BITS'(2);
          mode_nxt = M_IDENT;
        end else begin
          emit_a   = 1'b1;
          tok_a    = make_tok(K_ERROR, E_UNKNOWN, {56'd0, CH_UNDER}, '0, '0, tline_r, tcol_r);
          do_start = 1'b1;
        end
      end
      M_SLASH: begin
        if (text_byte == CH_SLASH) begin
          mode_nxt = M_COMMENT;
        end else begin
          emit_a   = 1'b1;
          tok_a    = make_tok(K_SLASH, E_NONE, '0, '0, '0, tline_r, tcol_r);
          do_start = 1'b1;
        end
      end
      M_COMMENT: begin
        do_start = (text_byte == CH_NL) || (text_byte == CH_NUL);
      end
      M_CHAR1: begin
        if ((text_byte != CH_NUL) && char_ok(text_byte)) begin
          acc_nxt  = byte_val;
          mode_nxt = M_CHAR2;
        end else begin
          emit_a   = 1'b1;
          tok_a    = make_tok(K_ERROR, E_BAD_CHAR, byte_val, '0, '0, tline_r, tcol_r);
          mode_nxt = M_IDLE;
          do_start = (text_byte == CH_NUL);
        end
      end
      M_CHAR2: begin
        if (text_byte == CH_QUOTE) begin
          emit_a   = 1'b1;
          tok_a    = make_tok(K_CHAR, E_NONE, acc_r, '0, '0, tline_r, tcol_r);
          mode_nxt = M_IDLE;
        end else begin
          emit_a   = 1'b1;
          tok_a    = make_tok(K_ERROR, E_NO_CLOSE, '0, '0, '0, tline_r, tcol_r);
          do_start = 1'b1;
        end
      end
      M_STRING: begin
        if (text_byte == CH_DQUOTE) begin
          emit_a   = 1'b1;
          tok_a    = make_tok(K_STRING, E_NONE, '0, '0, len_r, tline_r, tcol_r);
          mode_nxt = M_IDLE;
        end else if (text_byte == CH_NUL) begin
          emit_a   = 1'b1;
          tok_a    = make_tok(K_ERROR, E_NO_CLOSE, '0, '0, '0, tline_r, tcol_r);
          do_start = 1'b1;
        end else if (len_r != LEN_MAX) begin
          len_nxt = len_r + LENGTH_BITS'(1);
        end
      end
      default: begin
        mode_nxt = M_IDLE;
      end
    endcase
    if (do_start) begin
      mode_nxt  = st_mode;
      acc_nxt   = st_acc;
      frac_nxt  = '0;
      len_nxt   = st_len;
      tline_nxt = line_r;
      tcol_nxt  = col_r;
    end
  end

  // position and newline-run tracking
  always_comb begin
    line_nxt = line_r;
    col_nxt  = col_r;
    if (text_byte == CH_NL) begin
      if (line_r != POS_MAX) line_nxt = line_r + LINE_BITS'(1);
      col_nxt = '0;
    end else if ((text_byte != CH_NUL) && (col_r != POS_MAX)) begin
      col_nxt = col_r + LINE_BITS'(1);
    end
    if (do_start && st_emit) begin
      lwn_nxt = (st_tok.kind == K_NEWLINE);
    end else if (emit_a) begin
      lwn_nxt = 1'b0;
    end else begin
      lwn_nxt = lwn_r;
    end
  end

  // pack the tokens of this beat in order
  always_comb begin
    push = '0;
    n    = 2'd0;
    if (emit_a) begin
      push.tok[n] = tok_a;
      n           = n + 2'd1;
    end
    if (emit_b) begin
      push.tok[n] = tok_b;
      n           = n + 2'd1;
    end
    if (do_start && st_emit) begin
      push.tok[n] = st_tok;
      n           = n + 2'd1;
    end
    if (n != 2'd0) push.tok[n - 2'd1].last = 1'b1;
    push.cnt = accept ? n : 2'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= M_IDLE;
      acc_r   <= '0;
      frac_r  <= '0;
      len_r   <= '0;
      line_r  <= '0;
      col_r   <= '0;
      tline_r <= '0;
      tcol_r  <= '0;
      dline_r <= '0;
      dcol_r  <= '0;
      lwn_r   <= 1'b0;
    end else if (accept) begin
      mode_r  <= mode_nxt;
      acc_r   <= acc_nxt;
      frac_r  <= frac_nxt;
      len_r   <= len_nxt;
      line_r  <= line_nxt;
      col_r   <= col_nxt;
      tline_r <= tline_nxt;
      tcol_r  <= tcol_nxt;
      dline_r <= dline_nxt;
      dcol_r  <= dcol_nxt;
      lwn_r   <= lwn_nxt;
    end
  end

endmodule

@@ rtl/stt_token_fifo.sv @@
// token queue: takes up to three tokens a cycle, gives one a cycle while pop is high
// depends on stt_pkg
module stt_token_fifo
  import stt_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  push_t              push,
  input  logic               pop,
  output tok_t               head,
  output logic [FIFO_AW:0]   count
);

  tok_t                 mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_AW:0]     count_r, count_nxt;

  assign head  = mem_r[rd_ptr_r];
  assign count = count_r;

  assign wr_ptr_nxt = wr_ptr_r + FIFO_AW'(push.cnt);
  assign rd_ptr_nxt = rd_ptr_r + FIFO_AW'(pop);
  assign count_nxt  = count_r + (FIFO_AW + 1)'(push.cnt) - (FIFO_AW + 1)'(pop);

  always_ff @(posedge clk) begin
    for (int i = 0; i < PUSH_MAX; i++) begin
      if (2'(i) < push.cnt) mem_r[wr_ptr_r + FIFO_AW'(i)] <= push.tok[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

@@ rtl/source_text_tokenizer.sv @@
// channel  dir  handshake            payload
// in_      in   in_valid / in_stall  in_text_byte
// out_     out  out_valid / out_stall token fields, out_last_of_run on final token of a byte
//
// one byte is lexed in the cycle it is accepted; its tokens land in an 8-entry queue
// bytes are taken every cycle while the queue has room for three tokens
// tokens leave one per cycle from the queue head while out_stall is low, so bytes that yield two or three
// tokens raise in_stall once the queue backs up
// synchronous active-low reset empties the queue and returns the lexer to line 0, column 0
// depends on stt_pkg, stt_lexer, stt_token_fifo and source_text_tokenizer_assert.svh
`include "source_text_tokenizer_assert.svh"

module source_text_tokenizer
  import stt_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_text_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [4:0]         out_token_kind,
  output logic [1:0]         out_error_code,
  output logic signed [63:0] out_token_value,
  output logic [5:0]         out_fraction_digits,
  output logic [7:0]         out_token_length,
  output logic [15:0]        out_start_line,
  output logic [15:0]        out_start_column,
  output logic               out_last_of_run
);

  logic             in_accept;
  logic             out_pop;
  push_t            push;
  tok_t             head;
  logic [FIFO_AW:0] fifo_count;

  assign in_stall  = fifo_count > (FIFO_AW + 1)'(FIFO_DEPTH - PUSH_MAX);
  assign in_accept = in_valid && !in_stall;
  assign out_valid = fifo_count != '0;
  assign out_pop   = out_valid && !out_stall;

  stt_lexer u_lexer (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (in_accept),
    .text_byte (in_text_byte),
    .push      (push)
  );

  stt_token_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (out_pop),
    .head  (head),
    .count (fifo_count)
  );

  assign out_token_kind      = head.kind;
  assign out_error_code      = head.code;
  assign out_token_value     = $signed(head.value);
  assign out_fraction_digits = head.frac;
  assign out_token_length    = head.len;
  assign out_start_line      = head.ln;
  assign out_start_column    = head.col;
  assign out_last_of_run     = head.last;

  `STT_ASSERT_IMP(a_room_on_accept, in_accept, fifo_count <= (FIFO_AW + 1)'(FIFO_DEPTH - PUSH_MAX))
  `STT_ASSERT_IMP(a_end_emits, in_accept && (in_text_byte == CH_NUL), push.cnt != 2'd0)
  `STT_ASSERT_IMP(a_no_push_idle, !in_accept, push.cnt == 2'd0)
  `STT_ASSERT_NXT(a_count_hold, !in_accept && !out_pop, $stable(fifo_count))

endmodule

@@ tb/tb_source_text_tokenizer.sv @@
// testbench for source_text_tokenizer: streams source bytes, predicts every token in a
// local lexer copy and checks each result beat field by field against the oldest token due
// depends on stt_pkg and the source_text_tokenizer rtl
`timescale 1ns / 1ps

module tb_source_text_tokenizer;
  import stt_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 16;
  localparam int HOLD_CYCLES    = 80;
  localparam int RANDOM_ITEMS   = 85;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [7:0]         in_text_byte = 8'h00;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [4:0]         out_token_kind;
  logic [1:0]         out_error_code;
  logic signed [63:0] out_token_value;
  logic [5:0]         out_fraction_digits;
  logic [7:0]         out_token_length;
  logic [15:0]        out_start_line;
  logic [15:0]        out_start_column;
  logic               out_last_of_run;

  source_text_tokenizer dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_text_byte        (in_text_byte),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_token_kind      (out_token_kind),
    .out_error_code      (out_error_code),
    .out_token_value     (out_token_value),
    .out_fraction_digits (out_fraction_digits),
    .out_token_length    (out_token_length),
    .out_start_line      (out_start_line),
    .out_start_column    (out_start_column),
    .out_last_of_run     (out_last_of_run)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // lexer copy
  lex_mode_t   mode = M_IDLE;
  logic [63:0] acc = '0;
  logic [5:0]  frac_cnt = '0;
  logic [7:0]  body_len = '0;
  logic [15:0] cur_line = '0;
  logic [15:0] cur_col = '0;
  logic [15:0] tok_line = '0;
  logic [15:0] tok_col = '0;
  logic [15:0] dot_line = '0;
  logic [15:0] dot_col = '0;
  bit          prev_newline = 1'b0;
  tok_t        fresh[$];
  tok_t        tokens_due[$];

  int mismatch_count = 0;
  int idle_cycles = 0;
  int bytes_sent = 0;
  int burst_left = 0;
  int gap_max = 4;
  bit hold_request = 1'b0;
  int hold_left = 0;
  int stall_style = 0;
  int stall_phase = 0;

  function automatic bit digit_byte(logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic bit letter_byte(logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
  endfunction

  function automatic bit word_byte(logic [7:0] b);
    return digit_byte(b) || letter_byte(b) || b == CH_UNDER;
  endfunction

  function automatic bit space_byte(logic [7:0] b);
    return b == CH_SPACE || b == CH_TAB || b == CH_VT || b == CH_FF || b == CH_CR;
  endfunction

  function automatic bit literal_byte(logic [7:0] b);
    return (b >= CH_SPACE && b <= 8'h7E) || (b >= CH_TAB && b <= CH_CR);
  endfunction

  function automatic logic [63:0] scaled(logic [63:0] v, logic [7:0] b);
    logic [63:0] d;
    d = {56'd0, b - 8'h30};
    if (v > (VAL_MAX - d) / 10) return VAL_MAX;
    return v * 10 + d;
  endfunction

  task automatic put_token(input logic [4:0] kind, input logic [1:0] code,
                           input logic [63:0] value, input logic [5:0] frac,
                           input logic [7:0] len, input logic [15:0] ln,
                           input logic [15:0] col);
    tok_t t;
    if (fresh.size() < 3) begin
      t.kind  = kind;
      t.code  = code;
      t.value = value;
      t.frac  = frac;
      t.len   = len;
      t.ln    = ln;
      t.col   = col;
      t.last  = 1'b0;
      fresh.push_back(t);
      prev_newline = (kind == K_NEWLINE);
    end
  endtask

  task automatic put_here(input logic [4:0] kind, input logic [1:0] code,
                          input logic [63:0] value, input logic [5:0] frac,
                          input logic [7:0] len);
    put_token(kind, code, value, frac, len, tok_line, tok_col);
  endtask

  task automatic begin_token(input logic [7:0] b);
    tok_line = cur_line;
    tok_col  = cur_col;
    acc      = '0;
    frac_cnt = '0;
    body_len = '0;
    mode     = M_IDLE;
    if (b == CH_NUL) put_here(K_END, E_NONE, 64'd0, 6'd0, 8'd0);
    else if (b == CH_NL) begin
      if (!prev_newline) put_here(K_NEWLINE, E_NONE, 64'd0, 6'd0, 8'd0);
    end else if (space_byte(b)) begin
    end else if (b == CH_QUOTE) mode = M_CHAR1;
    else if (b == CH_DQUOTE) mode = M_STRING;
    else if (digit_byte(b)) begin
      acc  = scaled(acc, b);
      mode = M_INT;
    end else if (b == CH_DOT) mode = M_DOT;
    else if (letter_byte(b)) begin
      body_len = 8'd1;
      mode     = M_IDENT;
    end else if (b == CH_UNDER) mode = M_UNDER;
    else if (b == CH_SLASH) mode = M_SLASH;
    else begin
      case (b)
        CH_SEMI:   put_here(K_SEMI, E_NONE, 64'd0, 6'd0, 8'd0);
        CH_LPAREN: put_here(K_LPAREN, E_NONE, 64'd0, 6'd0, 8'd0);
        CH_RPAREN: put_here(K_RPAREN, E_NONE, 64'd0, 6'd0, 8'd0);
        CH_EQ:     put_here(K_ASSIGN, E_NONE, 64'd0, 6'd0, 8'd0);
        CH_COLON:  put_here(K_COLON, E_NONE, 64'd0, 6'd0, 8'd0);
        CH_PLUS:   put_here(K_PLUS, E_NONE, 64'd0, 6'd0, 8'd0);
        CH_MINUS:  put_here(K_MINUS, E_NONE, 64'd0, 6'd0, 8'd0);
        CH_STAR:   put_here(K_STAR, E_NONE, 64'd0, 6'd0, 8'd0);
        default:   put_here(K_ERROR, E_UNKNOWN, {56'd0, b}, 6'd0, 8'd0);
      endcase
    end
  endtask

  task automatic lex_byte(input logic [7:0] b);
    fresh.delete();
    case (mode)
      M_IDENT: begin
        if (word_byte(b)) begin
          if (body_len < LEN_MAX) body_len++;
        end else begin
          put_here(K_IDENT, E_NONE, 64'd0, 6'd0, body_len);
          begin_token(b);
        end
      end
      M_INT: begin
        if (digit_byte(b)) acc = scaled(acc, b);
        else if (b == CH_DOT) begin
          dot_line = cur_line;
          dot_col  = cur_col;
          mode     = M_INT_DOT;
        end else begin
          put_here(K_INT, E_NONE, acc, 6'd0, 8'd0);
          begin_token(b);
        end
      end
      M_INT_DOT, M_DOT: begin
        if (digit_byte(b)) begin
          acc      = scaled(acc, b);
          frac_cnt = 6'd1;
          mode     = M_FRAC;
        end else begin
          if (mode == M_INT_DOT) begin
            put_here(K_INT, E_NONE, acc, 6'd0, 8'd0);
            put_token(K_ERROR, E_UNKNOWN, {56'd0, CH_DOT}, 6'd0, 8'd0, dot_line, dot_col);
          end else put_here(K_ERROR, E_UNKNOWN, {56'd0, CH_DOT}, 6'd0, 8'd0);
          begin_token(b);
        end
      end
      M_FRAC: begin
        if (digit_byte(b)) begin
          acc = scaled(acc, b);
          if (frac_cnt < FRAC_MAX) frac_cnt++;
        end else begin
          put_here(K_DEC, E_NONE, acc, frac_cnt, 8'd0);
          begin_token(b);
        end
      end
      M_UNDER: begin
        if (word_byte(b)) begin
          body_len = 8'd2;
          mode     = M_IDENT;
        end else begin
          put_here(K_ERROR, E_UNKNOWN, {56'd0, CH_UNDER}, 6'd0, 8'd0);
          begin_token(b);
        end
      end
      M_SLASH: begin
        if (b == CH_SLASH) mode = M_COMMENT;
        else begin
          put_here(K_SLASH, E_NONE, 64'd0, 6'd0, 8'd0);
          begin_token(b);
        end
      end
      M_COMMENT: begin
        if (b == CH_NL || b == CH_NUL) begin_token(b);
      end
      M_CHAR1: begin
        if (b != CH_NUL && literal_byte(b)) begin
          acc  = {56'd0, b};
          mode = M_CHAR2;
        end else begin
          put_here(K_ERROR, E_BAD_CHAR, {56'd0, b}, 6'd0, 8'd0);
          mode = M_IDLE;
          if (b == CH_NUL) begin_token(b);
        end
      end
      M_CHAR2: begin
        if (b == CH_QUOTE) begin
          put_here(K_CHAR, E_NONE, acc, 6'd0, 8'd0);
          mode = M_IDLE;
        end else begin
          put_here(K_ERROR, E_NO_CLOSE, 64'd0, 6'd0, 8'd0);
          begin_token(b);
        end
      end
      M_STRING: begin
        if (b == CH_DQUOTE) begin
          put_here(K_STRING, E_NONE, 64'd0, 6'd0, body_len);
          mode = M_IDLE;
        end else if (b == CH_NUL) begin
          put_here(K_ERROR, E_NO_CLOSE, 64'd0, 6'd0, 8'd0);
          begin_token(b);
        end else if (body_len < LEN_MAX) body_len++;
      end
      default: begin_token(b);
    endcase
    if (b != CH_NUL) begin
      if (b == CH_NL) begin
        if (cur_line != POS_MAX) cur_line++;
        cur_col = '0;
      end else if (cur_col != POS_MAX) cur_col++;
    end
    if (fresh.size() > 0) fresh[fresh.size() - 1].last = 1'b1;
    foreach (fresh[i]) tokens_due.push_back(fresh[i]);
  endtask

  task automatic flag_mismatch(input string msg);
    mismatch_count++;
    $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  task automatic check_field(input string name, input logic [63:0] got, input logic [63:0] want);
    if (got !== want) flag_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  always @(posedge clk) begin : monitor
    tok_t want;
    bit   moved;
    moved = 1'b0;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        lex_byte(in_text_byte);
        moved = 1'b1;
      end
      if (out_valid && !out_stall) begin
        moved = 1'b1;
        if (tokens_due.size() == 0) flag_mismatch("token beat with none due");
        else begin
          want = tokens_due.pop_front();
          check_field("kind", out_token_kind, want.kind);
          check_field("error_code", out_error_code, want.code);
          check_field("value", out_token_value, want.value);
          check_field("fraction_digits", out_fraction_digits, want.frac);
          check_field("length", out_token_length, want.len);
          check_field("line", out_start_line, want.ln);
          check_field("column", out_start_column, want.col);
          check_field("last_of_run", out_last_of_run, want.last);
        end
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("tb_source_text_tokenizer NOT OK");
        $finish;
      end
    end
  end

  // receiver stall pattern, with a long hold when a test requests one
  always @(negedge clk) begin
    if (hold_request) begin
      hold_left    = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      if (stall_phase == 0) begin
        stall_style = $urandom_range(0, 3);
        stall_phase = $urandom_range(20, 120);
      end
      stall_phase--;
      case (stall_style)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= stall_phase[2];
      endcase
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid     <= 1'b1;
    in_text_byte <= b;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic wait_drained;
    @(negedge clk);
    in_valid <= 1'b0;
    while (tokens_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [7:0] any_letter;
    return 8'(($urandom_range(0, 1) ? "a" : "A") + $urandom_range(0, 25));
  endfunction

  function automatic logic [7:0] any_digit;
    return 8'("0" + $urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] any_word;
    case ($urandom_range(0, 3))
      0: return any_digit();
      1: return CH_UNDER;
      default: return any_letter();
    endcase
  endfunction

  function automatic logic [7:0] any_punct;
    case ($urandom_range(0, 8))
      0: return CH_SEMI;
      1: return CH_LPAREN;
      2: return CH_RPAREN;
      3: return CH_EQ;
      4: return CH_COLON;
      5: return CH_PLUS;
      6: return CH_MINUS;
      7: return CH_STAR;
      default: return CH_SLASH;
    endcase
  endfunction

  function automatic logic [7:0] any_blank;
    case ($urandom_range(0, 5))
      0: return CH_TAB;
      1: return CH_VT;
      2: return CH_FF;
      3: return CH_CR;
      default: return CH_SPACE;
    endcase
  endfunction

  function automatic logic [7:0] any_printable;
    logic [7:0] b;
    b = 8'($urandom_range(32, 126));
    return (b == CH_DQUOTE) ? "x" : b;
  endfunction

  task automatic test_punctuators;
    send_text(";()=:+-*/ ");
    send_byte(CH_NUL);
    wait_drained();
  endtask

  task automatic test_literals;
    send_text("ab_9 _x 42 3.25 .5 'q' \"hi\"\n");
    wait_drained();
  endtask

  task automatic test_special_cases;
    // repeated newline across a comment, lone dot and underscore, digits then dot
    send_text("\n \n// note\n. _;7.+");
    // bad char literal bytes, one of them ending the source
    send_byte(CH_QUOTE);
    send_byte(8'h01);
    send_byte(CH_QUOTE);
    send_byte(CH_NUL);
    // unclosed char literal, unknown bytes
    send_text("'ab@");
    send_byte(8'hFF);
    send_byte(8'h80);
    // string hitting end, end with a pending token, comment hitting end
    send_text("\"abc");
    send_byte(CH_NUL);
    send_text("xy");
    send_byte(CH_NUL);
    send_text("//z");
    send_byte(CH_NUL);
    wait_drained();
  endtask

  task automatic test_backpressure;
    @(posedge clk);
    hold_request = 1'b1;
    gap_max = 0;
    repeat (8) send_text("1.;");
    gap_max = 4;
    wait_drained();
  endtask

  task automatic random_fragment;
    logic [7:0] b;
    case ($urandom_range(0, 15))
      0: begin
        send_byte($urandom_range(0, 3) == 0 ? CH_UNDER : any_letter());
        repeat ($urandom_range(0, 6)) send_byte(any_word());
      end
      1: repeat ($urandom_range(0, 7) == 0 ? $urandom_range(18, 22) : $urandom_range(1, 5))
           send_byte(any_digit());
      2: begin
        if ($urandom_range(0, 2) != 0) repeat ($urandom_range(1, 4)) send_byte(any_digit());
        send_byte(CH_DOT);
        repeat ($urandom_range(1, 5)) send_byte(any_digit());
      end
      3: begin
        send_byte(CH_QUOTE);
        send_byte($urandom_range(0, 4) == 0 ? 8'($urandom_range(9, 13))
                                             : 8'($urandom_range(32, 126)));
        send_byte(CH_QUOTE);
      end
      4: begin
        send_byte(CH_DQUOTE);
        repeat ($urandom_range(0, 8)) begin
          b = 8'($urandom_range(1, 255));
          send_byte(b == CH_DQUOTE ? any_printable() : b);
        end
        send_byte(CH_DQUOTE);
      end
      5: begin
        send_text("//");
        repeat ($urandom_range(0, 6)) begin
          b = 8'($urandom_range(1, 255));
          send_byte(b == CH_NL ? CH_SPACE : b);
        end
        send_byte(CH_NL);
      end
      6: send_byte(any_punct());
      7: repeat ($urandom_range(1, 3)) send_byte(CH_NL);
      8: send_byte(CH_NUL);
      9: send_byte(8'($urandom_range(0, 255)));
      10: begin
        case ($urandom_range(0, 5))
          0: begin
            send_byte(CH_DOT);
            send_byte($urandom_range(0, 1) ? any_punct() : any_blank());
          end
          1: begin
            send_byte(CH_UNDER);
            send_byte(any_punct());
          end
          2: begin
            repeat ($urandom_range(1, 3)) send_byte(any_digit());
            send_byte(CH_DOT);
            send_byte($urandom_range(0, 1) ? any_letter() : any_punct());
          end
          3: begin
            send_byte(CH_QUOTE);
            send_byte($urandom_range(0, 1) ? 8'($urandom_range(0, 8))
                                           : 8'($urandom_range(127, 255)));
          end
          4: begin
            send_byte(CH_QUOTE);
            send_byte(any_printable());
            send_byte(any_word());
          end
          default: begin
            send_byte(CH_DQUOTE);
            repeat ($urandom_range(0, 4)) send_byte(any_printable());
            send_byte(CH_NUL);
          end
        endcase
      end
      default: send_byte($urandom_range(0, 1) ? any_blank() : any_punct());
    endcase
  endtask

  task automatic test_random_source;
    int start;
    start = bytes_sent;
    while (bytes_sent - start < RANDOM_ITEMS) random_fragment();
    wait_drained();
  endtask

  task automatic test_saturation;
    send_text("1.");
    repeat (66) send_byte(any_digit());
    send_byte(CH_SPACE);
    send_text(" 9223372036854775807 9223372036854775808 ");
    wait_drained();
  endtask

  task automatic test_positions;
    gap_max = 0;
    repeat (3) send_byte(CH_NL);
    repeat (6) send_byte(CH_SPACE);
    send_text("z;");
    send_byte(CH_NUL);
    gap_max = 4;
    wait_drained();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_punctuators();
    test_literals();
    test_special_cases();
    test_backpressure();
    test_random_source();
    test_saturation();
    test_positions();
    wait_drained();
    if (mismatch_count == 0) $display("tb_source_text_tokenizer OK");
    else $display("tb_source_text_tokenizer NOT OK");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/stt_pkg.sv
rtl/stt_lexer.sv
rtl/stt_token_fifo.sv
rtl/source_text_tokenizer.sv
tb/tb_source_text_tokenizer.sv
